// ----- src/midi_stale_drop_router_queue_core_defines.svh -----
// Assertion macros for the MIDI stale-drop router queue.
// Included by RTL files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef MIDI_STALE_DROP_ROUTER_QUEUE_CORE_DEFINES_SVH
`define MIDI_STALE_DROP_ROUTER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSDR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msdr assertion failed");

// Next-cycle implication, disabled during reset.
`define MSDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msdr assertion failed");

`endif

// ----- src/msdr_pkg.sv -----
// Shared types and constants for the MIDI stale-drop router queue.
// No dependencies; imported by msdr_deq_eval, the top level and the testbench.
`default_nettype none

package msdr_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_QUEUED    = 3'd0,
    KIND_CUT       = 3'd1,
    KIND_DELIVERED = 3'd2,
    KIND_STALE     = 3'd3,
    KIND_EMPTY     = 3'd4,
    KIND_CLEARED   = 3'd5,
    KIND_STATS_RST = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    REG_ACTIVE_IF  = 3'd0,
    REG_UART_CLK   = 3'd1,
    REG_UART_TRN   = 3'd2,
    REG_USB_CLK    = 3'd3,
    REG_USB_TRN    = 3'd4,
    REG_CUT_LOCAL  = 3'd5,
    REG_CLK_LIMIT  = 3'd6,
    REG_NOTE_LIMIT = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DEQ  = 2'b10
  } state_e;

  localparam logic [7:0]  STATUS_CLOCK    = 8'hF8;
  localparam logic [7:0]  STATUS_HI_MASK  = 8'hF0;
  localparam logic [7:0]  STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0]  STATUS_START    = 8'hFA;
  localparam logic [7:0]  STATUS_STOP     = 8'hFC;
  localparam logic [15:0] MIN_NOTE_LEN    = 16'd3;
  localparam logic [31:0] CLK_LIMIT_RST   = 32'd20000;
  localparam logic [31:0] NOTE_LIMIT_RST  = 32'd50000;

  // Entry layout: {time, len, third, status, tag}
  localparam int unsigned ENTRY_W = 80;

  typedef struct packed {
    logic [1:0]  active_if;
    logic        uart_clk;
    logic        uart_trn;
    logic        usb_clk;
    logic        usb_trn;
    logic        cut_local;
    logic [31:0] clk_limit;
    logic [31:0] note_limit;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic        send_uart;
    logic        send_usb;
    logic [31:0] age;
    logic        clock_drop;
    logic        note_drop;
  } deq_res_t;

endpackage

`default_nettype wire

// ----- src/msdr_deq_eval.sv -----
// Dequeue evaluation: age, stale test and UART/USB routing of one queue entry.
// Depends on msdr_pkg.
`default_nettype none

module msdr_deq_eval import msdr_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [31:0] now_i,
  input  logic [31:0] entry_time_i,
  input  logic [7:0]  status_i,
  input  logic [7:0]  third_i,
  input  logic [15:0] len_i,
  output deq_res_t    res_o
);

  logic [31:0] age;
  logic        is_clock;
  logic        is_note_on;
  logic        is_run_ctl;
  logic [7:0]  vel;
  logic        stale;
  logic        to_uart;
  logic        to_usb;

  assign age          = (now_i > entry_time_i) ? (now_i - entry_time_i) : '0;
  assign is_clock     = (status_i == STATUS_CLOCK);
  assign is_note_on   = ((status_i & STATUS_HI_MASK) == STATUS_NOTE_ON);
  assign is_run_ctl   = (status_i >= STATUS_START) && (status_i <= STATUS_STOP);
  assign vel          = (len_i < MIN_NOTE_LEN) ? 8'd0 : third_i;

  always_comb begin
    res_o.clock_drop = 1'b0;
    res_o.note_drop  = 1'b0;
    stale            = 1'b0;
    if (len_i == '0) begin
      stale = 1'b1;
    end else if (is_clock) begin
      if (age > cfg_i.clk_limit) begin
        res_o.clock_drop = 1'b1;
        stale            = 1'b1;
      end
    end else if (is_note_on) begin
      if ((vel != 8'd0) && (age > cfg_i.note_limit)) begin
        res_o.note_drop = 1'b1;
        stale           = 1'b1;
      end
    end

    to_uart = cfg_i.active_if[0];
    to_usb  = cfg_i.active_if[1];
    if (is_clock) begin
      to_uart = to_uart & cfg_i.uart_clk;
      to_usb  = to_usb & cfg_i.usb_clk;
    end
    if (is_run_ctl) begin
      to_uart = to_uart & cfg_i.uart_trn;
      to_usb  = to_usb & cfg_i.usb_trn;
    end

    res_o.age       = age;
    res_o.kind      = stale ? KIND_STALE : KIND_DELIVERED;
    res_o.send_uart = !stale && to_uart;
    res_o.send_usb  = !stale && to_usb;
  end

endmodule

`default_nettype wire

// ----- src/midi_stale_drop_router_queue_core.sv -----
// Top level of the MIDI stale-drop router queue: APB registers, queue memory, control.
// Depends on msdr_pkg, msdr_deq_eval and midi_stale_drop_router_queue_core_defines.svh.
//
// Usage:
//   Command channel (in_valid_i/in_ready_o) carries one command per transfer:
//   enqueue, dequeue, clear queue or reset statistics. Every command yields
//   exactly one result transfer on out_valid_o/out_ready_i, in order.
//   Enqueue, clear, statistics reset and dequeue of an empty queue have
//   the result registered at the accepting edge. A dequeue of a non-empty
//   queue first reads the queue memory into a register and then registers
//   the result; the block takes no command while that read is in flight.
//   Sustained rate is one command per cycle for those kinds while the
//   receiver takes each result; a non-empty dequeue ends before the next is taken.
//   The result sits in an output register; a new command is accepted while it
//   waits, as long as the register is taken in the same cycle. When the
//   receiver stalls, the block holds the result and stops accepting.
//   Reset empties the queue, zeroes the statistics and loads the register defaults;
//   no memory clearing pass is run. The user must write configuration over the APB
//   port (pready always high) only while the block is idle, which it does not enforce.
`default_nettype none
`include "midi_stale_drop_router_queue_core_defines.svh"

module midi_stale_drop_router_queue_core import msdr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] now_us_i,
  input  logic [15:0] msg_tag_i,
  input  logic [7:0]  status_byte_i,
  input  logic [7:0]  third_byte_i,
  input  logic [15:0] msg_len_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [15:0] out_tag_o,
  output logic        send_uart_o,
  output logic        send_usb_o,
  output logic [31:0] message_age_us_o,
  output logic [6:0]  queue_depth_o,
  output logic [6:0]  depth_high_mark_o,
  output logic [31:0] clock_drop_count_o,
  output logic [31:0] note_on_drop_count_o,
  output logic [31:0] overflow_drop_count_o,
  output logic [31:0] max_age_us_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // ---------------- configuration registers ----------------
  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_if  <= 2'b11;
      cfg_q.uart_clk   <= 1'b1;
      cfg_q.uart_trn   <= 1'b1;
      cfg_q.usb_clk    <= 1'b1;
      cfg_q.usb_trn    <= 1'b1;
      cfg_q.cut_local  <= 1'b0;
      cfg_q.clk_limit  <= CLK_LIMIT_RST;
      cfg_q.note_limit <= NOTE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE_IF:  cfg_q.active_if  <= pwdata[1:0];
        REG_UART_CLK:   cfg_q.uart_clk   <= pwdata[0];
        REG_UART_TRN:   cfg_q.uart_trn   <= pwdata[0];
        REG_USB_CLK:    cfg_q.usb_clk    <= pwdata[0];
        REG_USB_TRN:    cfg_q.usb_trn    <= pwdata[0];
        REG_CUT_LOCAL:  cfg_q.cut_local  <= pwdata[0];
        REG_CLK_LIMIT:  cfg_q.clk_limit  <= pwdata;
        REG_NOTE_LIMIT: cfg_q.note_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE_IF:  prdata = {30'd0, cfg_q.active_if};
      REG_UART_CLK:   prdata = {31'd0, cfg_q.uart_clk};
      REG_UART_TRN:   prdata = {31'd0, cfg_q.uart_trn};
      REG_USB_CLK:    prdata = {31'd0, cfg_q.usb_clk};
      REG_USB_TRN:    prdata = {31'd0, cfg_q.usb_trn};
      REG_CUT_LOCAL:  prdata = {31'd0, cfg_q.cut_local};
      REG_CLK_LIMIT:  prdata = cfg_q.clk_limit;
      REG_NOTE_LIMIT: prdata = cfg_q.note_limit;
      default:        prdata = '0;
    endcase
  end

  // ---------------- queue memory ----------------
  logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] wdata;
  logic               mem_we;
  logic               mem_re;

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;

  assign wdata = {now_us_i, msg_len_i, third_byte_i, status_byte_i, msg_tag_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[head_q];
    end
  end

  // ---------------- control and statistics ----------------
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] hmark_q, hmark_d;
  logic [31:0]      clk_drops_q, clk_drops_d;
  logic [31:0]      note_drops_q, note_drops_d;
  logic [31:0]      ovf_drops_q, ovf_drops_d;
  logic [31:0]      max_age_q, max_age_d;
  logic [31:0]      now_q, now_d;

  logic     in_xfer;
  logic     out_free;
  logic     deq_fire;
  cmd_e     cmd;
  deq_res_t deq_res;

  logic        res_load;
  kind_e       res_kind;
  logic [15:0] res_tag;
  logic        res_uart;
  logic        res_usb;
  logic [31:0] res_age;

  logic        out_valid_q, out_valid_d;
  kind_e       out_kind_q;
  logic [15:0] out_tag_q;
  logic        out_uart_q;
  logic        out_usb_q;
  logic [31:0] out_age_q;
  logic [6:0]  out_depth_q;
  logic [6:0]  out_hmark_q;
  logic [31:0] out_clk_drops_q;
  logic [31:0] out_note_drops_q;
  logic [31:0] out_ovf_drops_q;
  logic [31:0] out_max_age_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign deq_fire   = (state_q == ST_DEQ) && out_free;
  assign cmd        = cmd_e'(command_i);

  msdr_deq_eval u_deq_eval (
    .cfg_i        (cfg_q),
    .now_i        (now_q),
    .entry_time_i (rdata_q[79:48]),
    .status_i     (rdata_q[23:16]),
    .third_i      (rdata_q[31:24]),
    .len_i        (rdata_q[47:32]),
    .res_o        (deq_res)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    hmark_d      = hmark_q;
    clk_drops_d  = clk_drops_q;
    note_drops_d = note_drops_q;
    ovf_drops_d  = ovf_drops_q;
    max_age_d    = max_age_q;
    now_d        = now_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    res_load     = 1'b0;
    res_kind     = KIND_QUEUED;
    res_tag      = '0;
    res_uart     = 1'b0;
    res_usb      = 1'b0;
    res_age      = '0;

    if (in_xfer) begin
      unique case (cmd)
        CMD_ENQUEUE: begin
          res_load = 1'b1;
          if (cfg_q.cut_local) begin
            res_kind = KIND_CUT;
          end else begin
            mem_we = 1'b1;
            tail_d = next_idx(tail_q);
            if (count_q == FULL_CNT) begin
              head_d      = next_idx(head_q);
              ovf_drops_d = ovf_drops_q + 32'd1;
            end else begin
              count_d = count_q + 1'b1;
            end
            if (count_d > hmark_q) begin
              hmark_d = count_d;
            end
            res_kind = KIND_QUEUED;
          end
        end
        CMD_DEQUEUE: begin
          if (count_q == '0) begin
            res_load = 1'b1;
            res_kind = KIND_EMPTY;
          end else begin
            mem_re  = 1'b1;
            now_d   = now_us_i;
            state_d = ST_DEQ;
          end
        end
        CMD_CLEAR: begin
          head_d   = '0;
          tail_d   = '0;
          count_d  = '0;
          res_load = 1'b1;
          res_kind = KIND_CLEARED;
        end
        CMD_RESET: begin
          hmark_d      = '0;
          clk_drops_d  = '0;
          note_drops_d = '0;
          ovf_drops_d  = '0;
          max_age_d    = '0;
          res_load     = 1'b1;
          res_kind     = KIND_STATS_RST;
        end
        default: ;
      endcase
    end

    if (deq_fire) begin
      state_d      = ST_IDLE;
      head_d       = next_idx(head_q);
      count_d      = count_q - 1'b1;
      clk_drops_d  = clk_drops_q + {31'd0, deq_res.clock_drop};
      note_drops_d = note_drops_q + {31'd0, deq_res.note_drop};
      if (deq_res.age > max_age_q) begin
        max_age_d = deq_res.age;
      end
      res_load = 1'b1;
      res_kind = deq_res.kind;
      res_tag  = rdata_q[15:0];
      res_uart = deq_res.send_uart;
      res_usb  = deq_res.send_usb;
      res_age  = deq_res.age;
    end

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      hmark_q      <= '0;
      clk_drops_q  <= '0;
      note_drops_q <= '0;
      ovf_drops_q  <= '0;
      max_age_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      hmark_q      <= hmark_d;
      clk_drops_q  <= clk_drops_d;
      note_drops_q <= note_drops_d;
      ovf_drops_q  <= ovf_drops_d;
      max_age_q    <= max_age_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (res_load) begin
      out_kind_q       <= res_kind;
      out_tag_q        <= res_tag;
      out_uart_q       <= res_uart;
      out_usb_q        <= res_usb;
      out_age_q        <= res_age;
      out_depth_q      <= 7'(count_d);
      out_hmark_q      <= 7'(hmark_d);
      out_clk_drops_q  <= clk_drops_d;
      out_note_drops_q <= note_drops_d;
      out_ovf_drops_q  <= ovf_drops_d;
      out_max_age_q    <= max_age_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign result_kind_o         = out_kind_q;
  assign out_tag_o             = out_tag_q;
  assign send_uart_o           = out_uart_q;
  assign send_usb_o            = out_usb_q;
  assign message_age_us_o      = out_age_q;
  assign queue_depth_o         = out_depth_q;
  assign depth_high_mark_o     = out_hmark_q;
  assign clock_drop_count_o    = out_clk_drops_q;
  assign note_on_drop_count_o  = out_note_drops_q;
  assign overflow_drop_count_o = out_ovf_drops_q;
  assign max_age_us_o          = out_max_age_q;

  // ---------------- assertions ----------------
  `MSDR_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= FULL_CNT)
  `MSDR_ASSERT_IMPL(a_deq_nonempty, state_q == ST_DEQ, count_q != '0)
  `MSDR_ASSERT_IMPL(a_ptr_match, head_q == tail_q, (count_q == '0) || (count_q == FULL_CNT))
  `MSDR_ASSERT_NEXT(a_deq_read, mem_re, state_q == ST_DEQ)
  `MSDR_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q && $stable(out_tag_q))

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for midi_stale_drop_router_queue_core: directed and random command streams
// checked against an in-file queue/routing predictor, with APB configuration between phases.
// Depends on msdr_pkg and the RTL under src.
module tb import msdr_pkg::*; ();

  localparam int unsigned QDEPTH        = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] now_us;
    logic [15:0] tag;
    logic [7:0]  status;
    logic [7:0]  third;
    logic [15:0] len;
  } midi_cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tag;
    logic        uart;
    logic        usb;
    logic [31:0] age;
    logic [6:0]  depth;
    logic [6:0]  high_mark;
    logic [31:0] clk_drops;
    logic [31:0] note_drops;
    logic [31:0] ovf_drops;
    logic [31:0] max_age;
  } midi_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [31:0] now_us_i = '0;
  logic [15:0] msg_tag_i = '0;
  logic [7:0]  status_byte_i = '0;
  logic [7:0]  third_byte_i = '0;
  logic [15:0] msg_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [15:0] out_tag_o;
  logic        send_uart_o;
  logic        send_usb_o;
  logic [31:0] message_age_us_o;
  logic [6:0]  queue_depth_o;
  logic [6:0]  depth_high_mark_o;
  logic [31:0] clock_drop_count_o;
  logic [31:0] note_on_drop_count_o;
  logic [31:0] overflow_drop_count_o;
  logic [31:0] max_age_us_o;

  midi_stale_drop_router_queue_core #(.QUEUE_DEPTH(QDEPTH)) u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .command_i, .now_us_i, .msg_tag_i,
    .status_byte_i, .third_byte_i, .msg_len_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .out_tag_o, .send_uart_o,
    .send_usb_o, .message_age_us_o, .queue_depth_o, .depth_high_mark_o,
    .clock_drop_count_o, .note_on_drop_count_o, .overflow_drop_count_o,
    .max_age_us_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and shadow configuration
  midi_cmd_t    cmd_fifo[$];
  cfg_t         cfg_shadow;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  logic [31:0]  t_clock;

  // predicted queue contents and statistics
  logic [31:0]  ent_time [QDEPTH];
  midi_cmd_t    ent_msg [QDEPTH];
  logic [5:0]   q_head;
  logic [5:0]   q_tail;
  logic [6:0]   q_count;
  logic [6:0]   q_high_mark;
  logic [31:0]  q_clk_drops;
  logic [31:0]  q_note_drops;
  logic [31:0]  q_ovf_drops;
  logic [31:0]  q_max_age;
  midi_result_t expected_results[$];

  int unsigned  cmds_issued = 0;
  int unsigned  cmds_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;

  task automatic step_queue(input midi_cmd_t c, output midi_result_t r);
    logic [31:0] t;
    midi_cmd_t   m;
    logic [7:0]  vel;
    logic        stale;
    logic        is_clk;
    logic        is_trn;
    logic        u;
    logic        b;
    r = '0;
    case (c.cmd)
      CMD_ENQUEUE: begin
        if (cfg_shadow.cut_local) begin
          r.kind = KIND_CUT;
        end else begin
          if (q_count >= QDEPTH) begin
            q_head = q_head + 6'd1;
            q_count = q_count - 7'd1;
            q_ovf_drops = q_ovf_drops + 32'd1;
          end
          ent_time[q_tail] = c.now_us;
          ent_msg[q_tail] = c;
          q_tail = q_tail + 6'd1;
          q_count = q_count + 7'd1;
          if (q_count > q_high_mark) q_high_mark = q_count;
          r.kind = KIND_QUEUED;
        end
      end
      CMD_DEQUEUE: begin
        if (q_count == 0) begin
          r.kind = KIND_EMPTY;
        end else begin
          t = ent_time[q_head];
          m = ent_msg[q_head];
          vel = m.third;
          stale = 1'b0;
          q_head = q_head + 6'd1;
          q_count = q_count - 7'd1;
          r.tag = m.tag;
          r.age = (c.now_us > t) ? c.now_us - t : 32'd0;
          if (r.age > q_max_age) q_max_age = r.age;
          if (m.len == 0) begin
            stale = 1'b1;
          end else if (m.status == STATUS_CLOCK) begin
            if (r.age > cfg_shadow.clk_limit) begin
              q_clk_drops = q_clk_drops + 32'd1;
              stale = 1'b1;
            end
          end else if ((m.status & STATUS_HI_MASK) == STATUS_NOTE_ON) begin
            if (m.len < MIN_NOTE_LEN) vel = '0;
            if (vel != 0 && r.age > cfg_shadow.note_limit) begin
              q_note_drops = q_note_drops + 32'd1;
              stale = 1'b1;
            end
          end
          if (stale) begin
            r.kind = KIND_STALE;
          end else begin
            is_clk = (m.status == STATUS_CLOCK);
            is_trn = (m.status >= STATUS_START) && (m.status <= STATUS_STOP);
            u = cfg_shadow.active_if[0];
            b = cfg_shadow.active_if[1];
            if (is_clk) begin
              if (!cfg_shadow.uart_clk) u = 1'b0;
              if (!cfg_shadow.usb_clk) b = 1'b0;
            end
            if (is_trn) begin
              if (!cfg_shadow.uart_trn) u = 1'b0;
              if (!cfg_shadow.usb_trn) b = 1'b0;
            end
            r.uart = u;
            r.usb = b;
            r.kind = KIND_DELIVERED;
          end
        end
      end
      CMD_CLEAR: begin
        q_head = '0;
        q_tail = '0;
        q_count = '0;
        r.kind = KIND_CLEARED;
      end
      default: begin
        q_high_mark = '0;
        q_clk_drops = '0;
        q_note_drops = '0;
        q_ovf_drops = '0;
        q_max_age = '0;
        r.kind = KIND_STATS_RST;
      end
    endcase
    r.depth = q_count;
    r.high_mark = q_high_mark;
    r.clk_drops = q_clk_drops;
    r.note_drops = q_note_drops;
    r.ovf_drops = q_ovf_drops;
    r.max_age = q_max_age;
  endtask

  function automatic string fmt_result(midi_result_t r);
    return $sformatf({"kind=%0d tag=%h uart=%b usb=%b age=%0d depth=%0d hwm=%0d ",
                      "clk_drops=%0d note_drops=%0d ovf_drops=%0d max_age=%0d"},
                     r.kind, r.tag, r.uart, r.usb, r.age, r.depth, r.high_mark,
                     r.clk_drops, r.note_drops, r.ovf_drops, r.max_age);
  endfunction

  // driver: new transfer offered only once the previous one is taken
  always @(negedge clk_i) begin
    midi_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (cmds_issued == cmds_taken) begin
        if (cmd_fifo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          c = cmd_fifo.pop_front();
          command_i <= c.cmd;
          now_us_i <= c.now_us;
          msg_tag_i <= c.tag;
          status_byte_i <= c.status;
          third_byte_i <= c.third;
          msg_len_i <= c.len;
          in_valid_i <= 1'b1;
          cmds_issued <= cmds_issued + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: check results, predict on each accepted command, watchdog
  always @(posedge clk_i) begin
    midi_result_t got;
    midi_result_t want;
    midi_cmd_t    c;
    logic         fired;
    if (!rst_ni) begin
      q_head = '0;
      q_tail = '0;
      q_count = '0;
      q_high_mark = '0;
      q_clk_drops = '0;
      q_note_drops = '0;
      q_ovf_drops = '0;
      q_max_age = '0;
      stall_cycles = 0;
    end else begin
      fired = 1'b0;
      if (out_valid_o && out_ready_i) begin
        fired = 1'b1;
        got.kind = kind_e'(result_kind_o);
        got.tag = out_tag_o;
        got.uart = send_uart_o;
        got.usb = send_usb_o;
        got.age = message_age_us_o;
        got.depth = queue_depth_o;
        got.high_mark = depth_high_mark_o;
        got.clk_drops = clock_drop_count_o;
        got.note_drops = note_on_drop_count_o;
        got.ovf_drops = overflow_drop_count_o;
        got.max_age = max_age_us_o;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: %s", fmt_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        fired = 1'b1;
        c.cmd = cmd_e'(command_i);
        c.now_us = now_us_i;
        c.tag = msg_tag_i;
        c.status = status_byte_i;
        c.third = third_byte_i;
        c.len = msg_len_i;
        step_queue(c, want);
        expected_results.push_back(want);
        cmds_taken = cmds_taken + 1;
      end
      stall_cycles = fired ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL midi_stale_drop_router_queue_core");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE_IF:  cfg_shadow.active_if = val[1:0];
      REG_UART_CLK:   cfg_shadow.uart_clk = val[0];
      REG_UART_TRN:   cfg_shadow.uart_trn = val[0];
      REG_USB_CLK:    cfg_shadow.usb_clk = val[0];
      REG_USB_TRN:    cfg_shadow.usb_trn = val[0];
      REG_CUT_LOCAL:  cfg_shadow.cut_local = val[0];
      REG_CLK_LIMIT:  cfg_shadow.clk_limit = val;
      default:        cfg_shadow.note_limit = val;
    endcase
  endtask

  task automatic push_cmd(cmd_e c, logic [31:0] now_us, logic [15:0] tag,
                          logic [7:0] status, logic [7:0] third, logic [15:0] len);
    midi_cmd_t m;
    m.cmd = c;
    m.now_us = now_us;
    m.tag = tag;
    m.status = status;
    m.third = third;
    m.len = len;
    cmd_fifo.push_back(m);
  endtask

  task automatic push_random(cmd_e c);
    int unsigned x;
    logic [31:0] now_us;
    logic [7:0]  status;
    logic [7:0]  third;
    logic [15:0] len;
    x = $urandom_range(99);
    if (x < 3) begin
      now_us = $urandom();
    end else if (x < 6) begin
      now_us = t_clock - $urandom_range(5000);
    end else begin
      x = $urandom_range(99);
      if (x < 70)      t_clock = t_clock + $urandom_range(5000);
      else if (x < 95) t_clock = t_clock + $urandom_range(70000);
      else             t_clock = t_clock + $urandom_range(1000000);
      now_us = t_clock;
    end
    x = $urandom_range(99);
    if (x < 25)      status = STATUS_CLOCK;
    else if (x < 50) status = STATUS_NOTE_ON | 8'($urandom_range(15));
    else if (x < 65) status = 8'($urandom_range(STATUS_STOP, STATUS_START));
    else if (x < 75) status = ($urandom_range(1) != 0) ? 8'hF9 : 8'hFD;
    else             status = 8'($urandom());
    third = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom());
    x = $urandom_range(99);
    if (x < 5)       len = '0;
    else if (x < 15) len = 16'($urandom());
    else             len = 16'($urandom_range(3, 1));
    push_cmd(c, now_us, 16'($urandom()), status, third, len);
  endtask

  // enqueue fills that overflow, long drains, and mixed traffic
  task automatic fill_phase(int unsigned n_items);
    int unsigned left;
    int unsigned k;
    int unsigned r;
    int unsigned x;
    cmd_e        c;
    left = n_items;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 15)      k = $urandom_range(75, 60);
      else if (r < 30) k = $urandom_range(70, 10);
      else             k = $urandom_range(30, 8);
      if (k > left) k = left;
      repeat (k) begin
        if (r < 15) begin
          c = CMD_ENQUEUE;
        end else if (r < 30) begin
          c = CMD_DEQUEUE;
        end else begin
          x = $urandom_range(99);
          if (x < 50)      c = CMD_ENQUEUE;
          else if (x < 94) c = CMD_DEQUEUE;
          else if (x < 97) c = CMD_CLEAR;
          else             c = CMD_RESET;
        end
        push_random(c);
      end
      left = left - k;
    end
  endtask

  task automatic drain_to_idle();
    while (cmd_fifo.size() != 0 || cmds_issued != cmds_taken ||
           expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure_phase(int unsigned p);
    logic [31:0] clk_lim;
    logic [31:0] note_lim;
    clk_lim = $urandom_range(100000);
    note_lim = $urandom_range(100000);
    case (p)
      0: begin
        apb_write(REG_ACTIVE_IF, 32'd3);
        apb_write(REG_UART_CLK, 32'd1);
        apb_write(REG_UART_TRN, 32'd1);
        apb_write(REG_USB_CLK, 32'd1);
        apb_write(REG_USB_TRN, 32'd1);
        clk_lim = CLK_LIMIT_RST;
        note_lim = NOTE_LIMIT_RST;
      end
      1: begin
        apb_write(REG_ACTIVE_IF, 32'd2);
        apb_write(REG_UART_CLK, 32'd1);
        apb_write(REG_UART_TRN, 32'd0);
        apb_write(REG_USB_CLK, 32'd0);
        apb_write(REG_USB_TRN, 32'd1);
        clk_lim = '0;
        note_lim = '0;
      end
      2: begin
        apb_write(REG_ACTIVE_IF, 32'd0);
        apb_write(REG_UART_CLK, $urandom());
        apb_write(REG_UART_TRN, $urandom());
        apb_write(REG_USB_CLK, $urandom());
        apb_write(REG_USB_TRN, $urandom());
        clk_lim = '1;
        note_lim = '1;
      end
      3: begin
        apb_write(REG_ACTIVE_IF, 32'd1);
        apb_write(REG_UART_CLK, 32'd0);
        apb_write(REG_UART_TRN, 32'd0);
        apb_write(REG_USB_CLK, 32'd1);
        apb_write(REG_USB_TRN, 32'd1);
      end
      default: begin
        apb_write(REG_ACTIVE_IF, $urandom());
        apb_write(REG_UART_CLK, $urandom());
        apb_write(REG_UART_TRN, $urandom());
        apb_write(REG_USB_CLK, $urandom());
        apb_write(REG_USB_TRN, $urandom());
      end
    endcase
    apb_write(REG_CUT_LOCAL, (p == 3) ? 32'd1 : 32'd0);
    apb_write(REG_CLK_LIMIT, clk_lim);
    apb_write(REG_NOTE_LIMIT, note_lim);
  endtask

  initial begin
    cfg_shadow.active_if = 2'd3;
    cfg_shadow.uart_clk = 1'b1;
    cfg_shadow.uart_trn = 1'b1;
    cfg_shadow.usb_clk = 1'b1;
    cfg_shadow.usb_trn = 1'b1;
    cfg_shadow.cut_local = 1'b0;
    cfg_shadow.clk_limit = CLK_LIMIT_RST;
    cfg_shadow.note_limit = NOTE_LIMIT_RST;
    tx_idle_pct = 37;
    rx_idle_pct = 68;
    t_clock = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: empty dequeue, limit boundaries, time going backwards,
    // zero length, short and silent note-ons, transport, stats reset, clear
    push_cmd(CMD_DEQUEUE, 32'd0, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'hFFFF, STATUS_CLOCK, 8'hFF, 16'hFFFF);
    push_cmd(CMD_ENQUEUE, 32'd100, 16'h0000, STATUS_NOTE_ON, 8'h7F, 16'd3);
    push_cmd(CMD_DEQUEUE, 32'd20000, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_DEQUEUE, 32'd50101, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_ENQUEUE, 32'd1000, 16'h1234, 8'h9F, 8'h40, 16'd2);
    push_cmd(CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    push_cmd(CMD_ENQUEUE, 32'hFFFF_FFFF, 16'h00FF, STATUS_CLOCK, 8'h00, 16'd1);
    push_cmd(CMD_DEQUEUE, 32'd5, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_ENQUEUE, 32'd10, 16'hA5A5, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_DEQUEUE, 32'd10, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h5A5A, STATUS_CLOCK, 8'h01, 16'd1);
    push_cmd(CMD_DEQUEUE, 32'd20001, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h0001, STATUS_START, 8'h00, 16'd1);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h0002, STATUS_STOP, 8'h00, 16'd1);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h0003, STATUS_NOTE_ON, 8'h00, 16'd3);
    repeat (3) push_cmd(CMD_DEQUEUE, 32'd1000000, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_RESET, 32'd0, 16'h0000, 8'h00, 8'h00, 16'd0);
    push_cmd(CMD_CLEAR, 32'd0, 16'h0000, 8'h00, 8'h00, 16'd0);
    drain_to_idle();

    // UART only, clocks blocked on UART, transport blocked on USB, cut set
    apb_write(REG_ACTIVE_IF, 32'd1);
    apb_write(REG_UART_CLK, 32'd0);
    apb_write(REG_USB_TRN, 32'd0);
    apb_write(REG_CUT_LOCAL, 32'd1);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'hBEEF, STATUS_CLOCK, 8'h00, 16'd1);
    drain_to_idle();
    apb_write(REG_CUT_LOCAL, 32'd0);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h0010, STATUS_CLOCK, 8'h00, 16'd1);
    push_cmd(CMD_ENQUEUE, 32'd0, 16'h0011, 8'hFB, 8'h00, 16'd1);
    repeat (2) push_cmd(CMD_DEQUEUE, 32'd10, 16'h0000, 8'h00, 8'h00, 16'd0);
    drain_to_idle();

    for (int unsigned p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      configure_phase(p);
      fill_phase((p == 3) ? 120 : 350);
      drain_to_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS midi_stale_drop_router_queue_core");
    else
      $display("FAIL midi_stale_drop_router_queue_core");
    $finish;
  end

endmodule
